### sv/bpcg_pkg.sv
package bpcg_pkg;

    localparam int CHANNELS    = 8;
    localparam int BEAT_W      = 7;
    localparam int PHRASE_W    = 10;
    localparam int PULSE_W     = 16;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_BEATS_PER_BAR   = 3'd0,
        REG_BARS_PER_PHRASE = 3'd1,
        REG_PHRASE_MODE     = 3'd2,
        REG_ENGAGE_TICKS    = 3'd3,
        REG_SHORT_TICKS     = 3'd4
    } reg_idx_t;

    // Per-channel control for one tick
    typedef struct packed {
        logic accept;
        logic running;
        logic fire;
        logic gate_open;
        logic clk_in;
        logic clear;
        logic mute;
    } chan_ctl_t;

    typedef struct packed {
        logic clock_bit;
        logic reset_bit;
    } chan_out_t;

endpackage

### sv/bpcg_channel.sv
module bpcg_channel (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bpcg_pkg::chan_ctl_t        ctl,
    input  logic [bpcg_pkg::PULSE_W-1:0] engage_ticks,
    input  logic [bpcg_pkg::PULSE_W-1:0] short_ticks,
    output bpcg_pkg::chan_out_t        result
);
    import bpcg_pkg::*;

    logic [PULSE_W-1:0] clk_left_reg;
    logic [PULSE_W-1:0] clk_left_next;
    logic [PULSE_W-1:0] rst_left_reg;
    logic [PULSE_W-1:0] rst_left_next;

    always_comb
    begin
        logic [PULSE_W-1:0] c;
        logic [PULSE_W-1:0] r;
        c = clk_left_reg;
        r = rst_left_reg;
        result = '0;
        if (ctl.running)
        begin
            // retrigger keeps the longer of remaining and new length
            if (ctl.fire)
            begin
                if (engage_ticks > c)
                    c = engage_ticks;
                if (short_ticks > r)
                    r = short_ticks;
            end
            if (ctl.gate_open)
            begin
                if (ctl.clk_in && short_ticks > c)
                    c = short_ticks;
                if (c != '0)
                begin
                    result.clock_bit = !ctl.mute;
                    c = c - 1'b1;
                end
            end
            else
            begin
                c = '0;
            end
            if (r != '0)
            begin
                result.reset_bit = 1'b1;
                r = r - 1'b1;
            end
        end
        if (!ctl.accept)
        begin
            clk_left_next = clk_left_reg;
            rst_left_next = rst_left_reg;
        end
        else if (ctl.clear)
        begin
            clk_left_next = '0;
            rst_left_next = '0;
        end
        else
        begin
            clk_left_next = c;
            rst_left_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_left_reg <= '0;
            rst_left_reg <= '0;
        end
        else
        begin
            clk_left_reg <= clk_left_next;
            rst_left_reg <= rst_left_next;
        end
    end

endmodule

### sv/bar_phrase_clock_gate.sv
// Bar/phrase clock gate.
// Input stream (s_t*): one beat per sample tick carrying the master clock,
// run and reset levels plus per-channel arm levels and channel clocks.
// Output stream (m_t*): exactly one result beat per input beat with the
// per-channel clock and reset pulse bits, gate and armed flags, the running
// flag and the beat/bar/phrase counter after that tick.
// The result of a tick sits in the output register on the cycle after the
// input beat is taken. Throughput is one tick per cycle while the output
// register is not stalled; all edge detection, the counter and the eight
// channel pulse units update in the same cycle. s_tready stays high while
// the output register is empty or being drained, so a stalled receiver holds
// the result and back-pressures the input after one beat.
// Reset clears the edge history, counters (to 1), flags and pulse counters,
// arms the skip of the first master edge and loads the register defaults
// (4 beats, 8 bars, bar mode, pulses of 96 and 48 ticks).
// Registers on the APB port: 0x00 beats_per_bar, 0x04 bars_per_phrase,
// 0x08 phrase_mode_mask, 0x0C engage_pulse_ticks, 0x10 short_pulse_ticks.
module bar_phrase_clock_gate #(
    parameter int PHRASE_LIMIT = 999
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // master_level, run_level, reset_level, arm_levels[8], channel_clocks[8]
    input  logic [bpcg_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // clock_out[8], reset_out[8], active_mask[8], armed_mask[8], running,
    // beat_now[7], bar_now[7], phrase_now[10]
    output logic [bpcg_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bpcg_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bpcg_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bpcg_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import bpcg_pkg::*;

    // configuration
    logic [BEAT_W-1:0]   beats_per_bar_reg;
    logic [BEAT_W-1:0]   bars_per_phrase_reg;
    logic [CHANNELS-1:0] phrase_mode_reg;
    logic [PULSE_W-1:0]  engage_ticks_reg;
    logic [PULSE_W-1:0]  short_ticks_reg;
    reg_idx_t            cfg_idx;
    logic                cfg_wr;

    // state
    logic                prev_master_reg;
    logic                prev_run_reg;
    logic                prev_reset_reg;
    logic [CHANNELS-1:0] prev_arm_reg;
    logic                run_reg, run_next;
    logic                first_reg, first_next;
    logic [BEAT_W-1:0]   beat_reg, beat_next;
    logic [BEAT_W-1:0]   bar_reg, bar_next;
    logic [PHRASE_W-1:0] phrase_reg, phrase_next;
    logic [CHANNELS-1:0] armed_reg, armed_next;
    logic [CHANNELS-1:0] open_reg, open_next;

    // output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // input fields
    logic                master_in;
    logic                run_in;
    logic                reset_in;
    logic [CHANNELS-1:0] arm_in;
    logic [CHANNELS-1:0] chclk_in;

    logic                accept;
    logic                master_edge;
    logic                run_edge;
    logic                reset_edge;
    logic [CHANNELS-1:0] armed_mid;
    logic [CHANNELS-1:0] fire;
    logic [CHANNELS-1:0] open_mid;
    logic [CHANNELS-1:0] clock_bits;
    logic [CHANNELS-1:0] reset_bits;
    logic                beat_one;
    logic                bar_one;

    assign master_in = s_tdata[0];
    assign run_in    = s_tdata[1];
    assign reset_in  = s_tdata[2];
    assign arm_in    = s_tdata[3 +: CHANNELS];
    assign chclk_in  = s_tdata[3 + CHANNELS +: CHANNELS];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign master_edge = master_in && !prev_master_reg;
    assign run_edge    = run_in && !prev_run_reg;
    assign reset_edge  = reset_in && !prev_reset_reg;

    assign armed_mid = armed_reg ^ (arm_in & ~prev_arm_reg);
    assign beat_one  = (beat_reg == BEAT_W'(1));
    assign bar_one   = (bar_reg == BEAT_W'(1));

    // fire at bar start, or at phrase start for channels in phrase mode
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            fire[i] = run_reg && master_edge && beat_one && armed_mid[i] &&
                      (!phrase_mode_reg[i] || bar_one);
        end
    end

    assign open_mid = open_reg ^ fire;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        chan_ctl_t ctl;
        chan_out_t res;

        assign ctl.accept    = accept;
        assign ctl.running   = run_reg;
        assign ctl.fire      = fire[g];
        assign ctl.gate_open = open_mid[g];
        assign ctl.clk_in    = chclk_in[g];
        assign ctl.clear     = reset_edge;
        assign ctl.mute      = first_reg;

        bpcg_channel u_chan (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .engage_ticks (engage_ticks_reg),
            .short_ticks  (short_ticks_reg),
            .result       (res)
        );

        assign clock_bits[g] = res.clock_bit;
        assign reset_bits[g] = res.reset_bit;
    end

    // counter, run and reset handling
    always_comb
    begin
        logic [BEAT_W:0]   beat_sum;
        logic [BEAT_W:0]   bar_sum;
        logic [PHRASE_W:0] phrase_sum;
        beat_sum   = {1'b0, beat_reg} + 1'b1;
        bar_sum    = {1'b0, bar_reg};
        phrase_sum = {1'b0, phrase_reg};

        first_next  = first_reg;
        beat_next   = beat_reg;
        bar_next    = bar_reg;
        phrase_next = phrase_reg;
        armed_next  = armed_mid & ~fire;
        open_next   = run_reg ? open_mid : open_reg;
        run_next    = run_reg ^ run_edge;

        if (run_reg && master_edge && !reset_edge)
        begin
            if (first_reg)
            begin
                first_next = 1'b0;
            end
            else
            begin
                if (beat_sum > {1'b0, beats_per_bar_reg})
                begin
                    beat_next = BEAT_W'(1);
                    bar_sum   = bar_sum + 1'b1;
                end
                else
                begin
                    beat_next = beat_sum[BEAT_W-1:0];
                end
                if (bar_sum > {1'b0, bars_per_phrase_reg})
                begin
                    bar_next   = BEAT_W'(1);
                    phrase_sum = phrase_sum + 1'b1;
                    if (phrase_sum > (PHRASE_W+1)'(PHRASE_LIMIT))
                        phrase_next = PHRASE_W'(1);
                    else
                        phrase_next = phrase_sum[PHRASE_W-1:0];
                end
                else
                begin
                    bar_next = bar_sum[BEAT_W-1:0];
                end
            end
        end

        if (reset_edge)
        begin
            run_next    = 1'b0;
            beat_next   = BEAT_W'(1);
            bar_next    = BEAT_W'(1);
            phrase_next = PHRASE_W'(1);
            armed_next  = '0;
            open_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_master_reg <= 1'b0;
            prev_run_reg    <= 1'b0;
            prev_reset_reg  <= 1'b0;
            prev_arm_reg    <= '0;
            run_reg         <= 1'b0;
            first_reg       <= 1'b1;
            beat_reg        <= BEAT_W'(1);
            bar_reg         <= BEAT_W'(1);
            phrase_reg      <= PHRASE_W'(1);
            armed_reg       <= '0;
            open_reg        <= '0;
        end
        else if (accept)
        begin
            prev_master_reg <= master_in;
            prev_run_reg    <= run_in;
            prev_reset_reg  <= reset_in;
            prev_arm_reg    <= arm_in;
            run_reg         <= run_next;
            first_reg       <= first_next;
            beat_reg        <= beat_next;
            bar_reg         <= bar_next;
            phrase_reg      <= phrase_next;
            armed_reg       <= armed_next;
            open_reg        <= open_next;
        end
    end

    // result beat; hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {7'd0, phrase_next, bar_next, beat_next, run_next,
                            armed_next, open_next, reset_bits, clock_bits};
        end
    end

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_per_bar_reg   <= BEAT_W'(4);
            bars_per_phrase_reg <= BEAT_W'(8);
            phrase_mode_reg     <= '0;
            engage_ticks_reg    <= PULSE_W'(96);
            short_ticks_reg     <= PULSE_W'(48);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BEATS_PER_BAR:   beats_per_bar_reg   <= pwdata[BEAT_W-1:0];
                REG_BARS_PER_PHRASE: bars_per_phrase_reg <= pwdata[BEAT_W-1:0];
                REG_PHRASE_MODE:     phrase_mode_reg     <= pwdata[CHANNELS-1:0];
                REG_ENGAGE_TICKS:    engage_ticks_reg    <= pwdata[PULSE_W-1:0];
                REG_SHORT_TICKS:     short_ticks_reg     <= pwdata[PULSE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BEATS_PER_BAR:   prdata = CFG_DATA_W'(beats_per_bar_reg);
            REG_BARS_PER_PHRASE: prdata = CFG_DATA_W'(bars_per_phrase_reg);
            REG_PHRASE_MODE:     prdata = CFG_DATA_W'(phrase_mode_reg);
            REG_ENGAGE_TICKS:    prdata = CFG_DATA_W'(engage_ticks_reg);
            REG_SHORT_TICKS:     prdata = CFG_DATA_W'(short_ticks_reg);
            default:             prdata = '0;
        endcase
    end

endmodule
